>>> hw/rtl/dtt_pkg.sv
// Shared types, codes and constants of the dirty tile tracker.
package dtt_pkg;

  localparam int DEF_TILE_COLS   = 20;
  localparam int DEF_TILE_ROWS   = 15;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int NUM_SETS = 6;

  // Request codes on req_type.
  localparam logic [2:0] REQ_INVAL     = 3'd0;
  localparam logic [2:0] REQ_QUERY     = 3'd1;
  localparam logic [2:0] REQ_END_FRAME = 3'd2;
  localparam logic [2:0] REQ_CLR_FG    = 3'd3;
  localparam logic [2:0] REQ_CLR_SETS  = 3'd4;

  // Target codes on target_set.
  localparam logic [1:0] TGT_NEWEST = 2'd0;

  // Fixed set indexes.
  localparam logic [2:0] CARRY_SET   = 3'd3;
  localparam logic [2:0] FG_SET      = 3'd4;
  localparam logic [2:0] HALF_FG_SET = 3'd5;

  // Layer codes.
  localparam logic [1:0] LAYER_FG   = 2'd0;
  localparam logic [1:0] LAYER_HALF = 2'd1;
  localparam logic [1:0] LAYER_BG1  = 2'd2;

  // Rotating set indexes after reset.
  localparam logic [1:0] NEWEST_RST   = 2'd2;
  localparam logic [1:0] PREVIOUS_RST = 2'd1;
  localparam logic [1:0] OLDEST_RST   = 2'd0;
  localparam logic [1:0] LAST_ROT     = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [11:0] rect_left;
    logic signed [11:0] rect_top;
    logic signed [11:0] rect_right;
    logic signed [11:0] rect_bottom;
    logic [1:0]         target_set;
    logic [4:0]         tile_col;
    logic [3:0]         tile_row;
  } in_item_t;

  typedef struct packed {
    logic       redraw;
    logic [1:0] layer_code;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INVAL,
    OP_QUERY,
    OP_FRAME,
    OP_CLR_FG,
    OP_CLR_SETS
  } op_t;

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic [1:0] target;
    logic [5:0] col_lo;
    logic [4:0] col_hi;
    logic [6:0] row_lo;
    logic [6:0] row_hi;
    logic [4:0] q_col;
    logic [3:0] q_row;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } bk_state_t;

endpackage

>>> hw/rtl/dtt_front.sv
// Front end: accepts requests, clamps rectangles to tile bounds and classifies them.
module dtt_front #(
  parameter int TILE_COLS = dtt_pkg::DEF_TILE_COLS,
  parameter int TILE_ROWS = dtt_pkg::DEF_TILE_ROWS
) (
  input  logic             start,
  input  logic             q_full,
  input  dtt_pkg::in_item_t in_item,
  output logic             busy,
  output logic             push,
  output dtt_pkg::cmd_t    cmd
);

  localparam logic [6:0] ROW_LAST = 7'(TILE_ROWS - 1);
  localparam logic [6:0] COLS_LIM = 7'(TILE_COLS);
  localparam logic [6:0] ROWS_LIM = 7'(TILE_ROWS);

  logic signed [11:0] l_s, t_s, r_s, b_s;
  logic [11:0] l_pos, t_pos, r_clip, b_clip;
  logic [5:0]  col_lo;
  logic [4:0]  col_hi;
  logic [6:0]  row_lo;
  logic [6:0]  row_hi;
  logic [6:0]  b_row;
  logic        empty;
  logic        in_range;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    l_s = in_item.rect_left;
    t_s = in_item.rect_top;
    r_s = in_item.rect_right;
    b_s = in_item.rect_bottom;

    l_pos  = l_s[11] ? 12'd0 : l_s;
    t_pos  = t_s[11] ? 12'd0 : t_s;
    // Negative right or bottom edges above one tile span still truncate to tile zero.
    r_clip = r_s[11] ? 12'd0 : ((r_s > 12'sd639) ? 12'd639 : r_s);
    b_clip = b_s[11] ? 12'd0 : ((b_s > 12'sd239) ? 12'd239 : b_s);

    col_lo = l_pos[10:5];
    row_lo = t_pos[10:4];
    col_hi = r_clip[9:5];
    b_row  = {3'd0, b_clip[7:4]};
    row_hi = (b_row > ROW_LAST) ? ROW_LAST : b_row;

    empty = (r_s <= -12'sd32) || (b_s <= -12'sd16) ||
            (col_lo > {1'b0, col_hi}) || (row_lo > row_hi) ||
            ({1'b0, col_lo} >= COLS_LIM);

    in_range = ({2'd0, in_item.tile_col} < COLS_LIM) &&
               ({3'd0, in_item.tile_row} < ROWS_LIM);

    cmd        = '0;
    cmd.target = in_item.target_set;
    cmd.col_lo = col_lo;
    cmd.col_hi = col_hi;
    cmd.row_lo = row_lo;
    cmd.row_hi = row_hi;
    cmd.q_col  = in_item.tile_col;
    cmd.q_row  = in_item.tile_row;
    unique case (in_item.req_type)
      dtt_pkg::REQ_INVAL:     cmd.op = empty ? dtt_pkg::OP_NOP : dtt_pkg::OP_INVAL;
      dtt_pkg::REQ_QUERY:     cmd.op = in_range ? dtt_pkg::OP_QUERY : dtt_pkg::OP_NOP;
      dtt_pkg::REQ_END_FRAME: cmd.op = dtt_pkg::OP_FRAME;
      dtt_pkg::REQ_CLR_FG:    cmd.op = dtt_pkg::OP_CLR_FG;
      dtt_pkg::REQ_CLR_SETS:  cmd.op = dtt_pkg::OP_CLR_SETS;
      default:                cmd.op = dtt_pkg::OP_NOP;
    endcase
  end

endmodule

>>> hw/rtl/dtt_queue.sv
// Short queue of classified requests between the front end and the back end.
module dtt_queue #(
  parameter int DEPTH = dtt_pkg::DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dtt_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output dtt_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  dtt_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/dtt_back.sv
// Back end: holds the six tile bitmaps and carries out requests one tile row a cycle.
module dtt_back #(
  parameter int TILE_COLS = dtt_pkg::DEF_TILE_COLS,
  parameter int TILE_ROWS = dtt_pkg::DEF_TILE_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               q_valid,
  input  dtt_pkg::cmd_t      q_head,
  output logic               pop,
  output logic               out_valid,
  output dtt_pkg::out_item_t out_item
);

  localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TILE_ROWS - 1);

  dtt_pkg::bk_state_t state_r, state_nxt;
  dtt_pkg::cmd_t      cur_r, cur_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   end_r, end_nxt;
  logic [2:0]         tgt_r, tgt_nxt;
  logic [1:0]         newest_r, newest_nxt;
  logic [1:0]         previous_r, previous_nxt;
  logic [1:0]         oldest_r, oldest_nxt;
  logic               render_en_r;
  logic               out_valid_r, out_valid_nxt;
  dtt_pkg::out_item_t out_item_r, out_item_nxt;

  logic [TILE_COLS-1:0] rows_r  [dtt_pkg::NUM_SETS][TILE_ROWS];
  logic [TILE_COLS-1:0] rd      [dtt_pkg::NUM_SETS];
  logic [TILE_COLS-1:0] wr_data [dtt_pkg::NUM_SETS];
  logic [dtt_pkg::NUM_SETS-1:0] wr_en;
  logic [TILE_COLS-1:0] col_mask;

  logic [ROW_W-1:0] rd_row;
  logic [6:0]       q_row_ext;
  logic [5:0]       q_col_ext;
  logic [COL_W-1:0] q_col;
  logic             walk_last;
  logic             older, any_set, fg_hit, half_hit;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign walk_last = (row_r == end_r);
  assign pop       = (state_r == dtt_pkg::BK_IDLE) && q_valid;

  assign q_row_ext = {3'd0, q_head.q_row};
  assign q_col_ext = {1'b0, q_head.q_col};
  assign q_col     = q_col_ext[COL_W-1:0];
  // The row walk and a query never overlap, so each set is read at one row only.
  assign rd_row    = (state_r == dtt_pkg::BK_IDLE) ? q_row_ext[ROW_W-1:0] : row_r;

  always_comb begin
    for (int s = 0; s < dtt_pkg::NUM_SETS; s++) begin
      rd[s] = rows_r[s][rd_row];
    end
    for (int c = 0; c < TILE_COLS; c++) begin
      col_mask[c] = (7'(c) >= {1'b0, cur_r.col_lo}) && (7'(c) <= {2'd0, cur_r.col_hi});
    end
  end

  // Query rule on the tile at the head of the queue.
  always_comb begin
    older    = rd[{1'b0, previous_r}][q_col] || rd[{1'b0, oldest_r}][q_col] ||
               rd[dtt_pkg::CARRY_SET][q_col];
    any_set  = older || rd[{1'b0, newest_r}][q_col];
    fg_hit   = rd[dtt_pkg::FG_SET][q_col];
    half_hit = rd[dtt_pkg::HALF_FG_SET][q_col];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtt_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_head.op) inside
            dtt_pkg::OP_INVAL, dtt_pkg::OP_CLR_FG, dtt_pkg::OP_CLR_SETS:
              state_nxt = dtt_pkg::BK_WALK;
            dtt_pkg::OP_FRAME:
              state_nxt = render_en_r ? dtt_pkg::BK_WALK : dtt_pkg::BK_IDLE;
            default:
              state_nxt = dtt_pkg::BK_IDLE;
          endcase
        end
      end
      dtt_pkg::BK_WALK: begin
        if (walk_last) begin
          state_nxt = dtt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dtt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    row_nxt       = row_r;
    end_nxt       = end_r;
    tgt_nxt       = tgt_r;
    newest_nxt    = newest_r;
    previous_nxt  = previous_r;
    oldest_nxt    = oldest_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    wr_en         = '0;
    for (int s = 0; s < dtt_pkg::NUM_SETS; s++) begin
      wr_data[s] = '0;
    end

    unique case (state_r)
      dtt_pkg::BK_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_head;
          row_nxt = '0;
          end_nxt = ROW_LAST;
          tgt_nxt = (q_head.target == dtt_pkg::TGT_NEWEST) ? {1'b0, newest_r} :
                                                             {1'b0, q_head.target} + 3'd2;
          case (q_head.op) inside
            dtt_pkg::OP_INVAL: begin
              row_nxt = q_head.row_lo[ROW_W-1:0];
              end_nxt = q_head.row_hi[ROW_W-1:0];
            end
            dtt_pkg::OP_FRAME: begin
              if (render_en_r) begin
                oldest_nxt   = previous_r;
                previous_nxt = newest_r;
                newest_nxt   = (newest_r == dtt_pkg::LAST_ROT) ? 2'd0 : newest_r + 2'd1;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            dtt_pkg::OP_QUERY: begin
              out_valid_nxt = 1'b1;
              if (render_en_r) begin
                if (fg_hit) begin
                  out_item_nxt.redraw     = any_set;
                  out_item_nxt.layer_code = dtt_pkg::LAYER_FG;
                end else if (half_hit) begin
                  out_item_nxt.redraw     = any_set;
                  out_item_nxt.layer_code = any_set ? dtt_pkg::LAYER_HALF : dtt_pkg::LAYER_FG;
                end else begin
                  out_item_nxt.redraw     = older;
                  out_item_nxt.layer_code = older ? dtt_pkg::LAYER_BG1 : dtt_pkg::LAYER_FG;
                end
              end
            end
            dtt_pkg::OP_CLR_FG, dtt_pkg::OP_CLR_SETS: begin
              out_valid_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      dtt_pkg::BK_WALK: begin
        row_nxt = row_r + ROW_W'(1);
        if (walk_last) begin
          out_valid_nxt = 1'b1;
        end
        for (int s = 0; s < dtt_pkg::NUM_SETS; s++) begin
          case (cur_r.op)
            dtt_pkg::OP_INVAL: begin
              wr_en[s]   = (3'(s) == tgt_r);
              wr_data[s] = rd[s] | col_mask;
            end
            dtt_pkg::OP_FRAME: begin
              // The rotation was applied when the request was taken.
              if (3'(s) == {1'b0, oldest_r}) begin
                wr_en[s]   = 1'b1;
                wr_data[s] = rd[s] | rd[dtt_pkg::CARRY_SET];
              end else if (3'(s) == {1'b0, newest_r} || 3'(s) == dtt_pkg::CARRY_SET) begin
                wr_en[s] = 1'b1;
              end
            end
            dtt_pkg::OP_CLR_FG: begin
              wr_en[s] = (3'(s) == dtt_pkg::FG_SET) || (3'(s) == dtt_pkg::HALF_FG_SET);
            end
            dtt_pkg::OP_CLR_SETS: begin
              wr_en[s] = (3'(s) < dtt_pkg::FG_SET);
            end
            default: begin
              wr_en[s] = 1'b0;
            end
          endcase
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtt_pkg::BK_IDLE;
      newest_r    <= dtt_pkg::NEWEST_RST;
      previous_r  <= dtt_pkg::PREVIOUS_RST;
      oldest_r    <= dtt_pkg::OLDEST_RST;
      render_en_r <= 1'b1;
      out_valid_r <= 1'b0;
      for (int s = 0; s < dtt_pkg::NUM_SETS; s++) begin
        for (int r = 0; r < TILE_ROWS; r++) begin
          rows_r[s][r] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      previous_r  <= previous_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        render_en_r <= cfg_wdata;
      end
      for (int s = 0; s < dtt_pkg::NUM_SETS; s++) begin
        if (wr_en[s]) begin
          rows_r[s][row_r] <= wr_data[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    row_r      <= row_nxt;
    end_r      <= end_nxt;
    tgt_r      <= tgt_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef SYNTH
  a_rot_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (newest_r != previous_r) && (newest_r != oldest_r) && (previous_r != oldest_r) &&
    (newest_r <= dtt_pkg::LAST_ROT) && (previous_r <= dtt_pkg::LAST_ROT) &&
    (oldest_r <= dtt_pkg::LAST_ROT))
    else $error("rotating set indexes collide");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtt_pkg::BK_WALK) |-> (row_r <= end_r))
    else $error("row walk ran past its last row");

  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtt_pkg::BK_WALK) && walk_last |=> out_valid_r)
    else $error("finished row walk gave no result");

  a_no_redraw_layer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.redraw |-> (out_item_r.layer_code == dtt_pkg::LAYER_FG))
    else $error("layer code set without redraw");
`endif

endmodule

>>> hw/rtl/dirty_tile_tracker.sv
// Top level of the dirty tile tracker: front end, request queue and back end.
//
// Requests are taken when start is high and busy is low; busy rises only while
// the request queue (QUEUE_DEPTH entries) is full. Every request gives exactly
// one result, shown for a single cycle with out_valid high, and the receiver
// cannot stall it. The back end takes one queued request per cycle when idle;
// a tile query, an ignored request or an end of frame with rendering disabled
// gives its result on the cycle after it is taken. An invalidate walks the
// covered tile rows, one row per cycle, and an end of frame or a clear walks all
// TILE_ROWS rows (15 by default), with its result in the cycle after the last
// row. The tile bitmaps sit in flip-flops that reset clears at once, so no
// clearing pass is needed. render_enable is written through cfg_we and
// cfg_wdata; the user must do so only while idle, as the block does not check.
module dirty_tile_tracker #(
  parameter int TILE_COLS   = dtt_pkg::DEF_TILE_COLS,
  parameter int TILE_ROWS   = dtt_pkg::DEF_TILE_ROWS,
  parameter int QUEUE_DEPTH = dtt_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dtt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dtt_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;
  dtt_pkg::cmd_t push_cmd;
  dtt_pkg::cmd_t q_head;

  dtt_front #(
    .TILE_COLS (TILE_COLS),
    .TILE_ROWS (TILE_ROWS)
  ) u_front (
    .start   (start),
    .q_full  (q_full),
    .in_item (in_item),
    .busy    (busy),
    .push    (push),
    .cmd     (push_cmd)
  );

  dtt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  dtt_back #(
    .TILE_COLS (TILE_COLS),
    .TILE_ROWS (TILE_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> tb/dirty_tile_tracker_check.sv
// Checker for the dirty tile tracker: predicts each request's result and compares it.
module dirty_tile_tracker_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  dtt_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  dtt_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS   = dtt_pkg::DEF_TILE_COLS;
  localparam int ROWS   = dtt_pkg::DEF_TILE_ROWS;
  localparam int MAX_X  = 639;
  localparam int MAX_Y  = 239;
  localparam int TILE_W = 32;
  localparam int TILE_H = 16;

  logic [COLS-1:0]    tile_map [dtt_pkg::NUM_SETS][ROWS];
  logic [1:0]         newest_idx;
  logic [1:0]         previous_idx;
  logic [1:0]         oldest_idx;
  logic               render_on;
  dtt_pkg::out_item_t expected_results[$];
  int                 errors = 0;

  function automatic void clear_map(input int s);
    for (int r = 0; r < ROWS; r++) tile_map[s][r] = '0;
  endfunction

  function automatic void mark_rect(input dtt_pkg::in_item_t req);
    int l, t, r, b, s;
    l = $signed(req.rect_left);
    t = $signed(req.rect_top);
    r = $signed(req.rect_right);
    b = $signed(req.rect_bottom);
    if (l < 0) l = 0;
    if (t < 0) t = 0;
    if (r > MAX_X) r = MAX_X;
    if (b > MAX_Y) b = MAX_Y;
    // Targets other than the newest set map onto the fixed sets above the rotating ones.
    s = (req.target_set == dtt_pkg::TGT_NEWEST) ? int'(newest_idx) :
                                                  int'(req.target_set) + 2;
    // Integer division truncates toward zero, so small negative right or bottom
    // values still reach column or row zero.
    for (int cx = l / TILE_W; cx <= r / TILE_W; cx++) begin
      if (cx < COLS) begin
        for (int cy = t / TILE_H; cy <= b / TILE_H; cy++) begin
          if (cy < ROWS) tile_map[s][cy][cx] = 1'b1;
        end
      end
    end
  endfunction

  function automatic dtt_pkg::out_item_t query_tile(input logic [4:0] col,
                                                    input logic [3:0] row);
    dtt_pkg::out_item_t res;
    logic               older, any_set;
    res = '{redraw: 1'b0, layer_code: dtt_pkg::LAYER_FG};
    if (render_on && col < COLS && row < ROWS) begin
      older   = tile_map[previous_idx][row][col] || tile_map[oldest_idx][row][col] ||
                tile_map[dtt_pkg::CARRY_SET][row][col];
      any_set = older || tile_map[newest_idx][row][col];
      if (tile_map[dtt_pkg::FG_SET][row][col]) begin
        if (any_set) res = '{redraw: 1'b1, layer_code: dtt_pkg::LAYER_FG};
      end else if (tile_map[dtt_pkg::HALF_FG_SET][row][col]) begin
        if (any_set) res = '{redraw: 1'b1, layer_code: dtt_pkg::LAYER_HALF};
      end else if (older) begin
        res = '{redraw: 1'b1, layer_code: dtt_pkg::LAYER_BG1};
      end
    end
    return res;
  endfunction

  function automatic void end_frame();
    if (render_on) begin
      oldest_idx   = previous_idx;
      previous_idx = newest_idx;
      newest_idx   = (newest_idx == dtt_pkg::LAST_ROT) ? 2'd0 : newest_idx + 2'd1;
      clear_map(newest_idx);
      for (int r = 0; r < ROWS; r++) begin
        tile_map[oldest_idx][r] |= tile_map[dtt_pkg::CARRY_SET][r];
      end
      clear_map(dtt_pkg::CARRY_SET);
    end
  endfunction

  function automatic dtt_pkg::out_item_t track_request(input dtt_pkg::in_item_t req);
    dtt_pkg::out_item_t res;
    res = '{redraw: 1'b0, layer_code: dtt_pkg::LAYER_FG};
    case (req.req_type)
      dtt_pkg::REQ_INVAL:     mark_rect(req);
      dtt_pkg::REQ_QUERY:     res = query_tile(req.tile_col, req.tile_row);
      dtt_pkg::REQ_END_FRAME: end_frame();
      dtt_pkg::REQ_CLR_FG: begin
        clear_map(dtt_pkg::FG_SET);
        clear_map(dtt_pkg::HALF_FG_SET);
      end
      dtt_pkg::REQ_CLR_SETS: begin
        for (int s = 0; s <= dtt_pkg::CARRY_SET; s++) clear_map(s);
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    dtt_pkg::out_item_t want;
    if (!rst_n) begin
      for (int s = 0; s < dtt_pkg::NUM_SETS; s++) clear_map(s);
      newest_idx   = dtt_pkg::NEWEST_RST;
      previous_idx = dtt_pkg::PREVIOUS_RST;
      oldest_idx   = dtt_pkg::OLDEST_RST;
      render_on    = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_we) render_on = cfg_wdata;
      // Results are retired before the new request is predicted; a request
      // never returns its result in the cycle it is taken.
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting, got redraw %0d layer %0d",
                   $time, out_item.redraw, out_item.layer_code);
        end else begin
          want = expected_results.pop_front();
          if (out_item.redraw !== want.redraw) begin
            errors++;
            $display("%0t: redraw mismatch, expected %0d, actual %0d",
                     $time, want.redraw, out_item.redraw);
          end
          if (out_item.layer_code !== want.layer_code) begin
            errors++;
            $display("%0t: layer_code mismatch, expected %0d, actual %0d",
                     $time, want.layer_code, out_item.layer_code);
          end
        end
      end
      if (start && !busy) expected_results.push_back(track_request(in_item));
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

>>> tb/dirty_tile_tracker_test.sv
// Top of the dirty tile tracker testbench: clock, reset, request stimulus and verdict.
module dirty_tile_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] TGT_CARRY = 2'd1;
  localparam logic [1:0] TGT_FG    = 2'd2;
  localparam logic [1:0] TGT_HALF  = 2'd3;

  localparam int PHASE_REQUESTS = 625;
  localparam int SETTLE_CYCLES  = 20;
  localparam int STALL_LIMIT    = 2000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  dtt_pkg::in_item_t  in_item;
  logic               out_valid;
  dtt_pkg::out_item_t out_item;
  logic               cfg_we;
  logic               cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 quiet_cycles = 0;
  int                 gap_pct = 26;

  dirty_tile_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dirty_tile_tracker_check tile_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A run that stops moving ends here.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic dtt_pkg::in_item_t noise_request();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return dtt_pkg::in_item_t'(raw[$bits(dtt_pkg::in_item_t)-1:0]);
  endfunction

  function automatic dtt_pkg::in_item_t rect_request(input int l, input int t, input int r,
                                                     input int b, input logic [1:0] tgt);
    dtt_pkg::in_item_t req;
    req             = noise_request();
    req.req_type    = dtt_pkg::REQ_INVAL;
    req.rect_left   = 12'(l);
    req.rect_top    = 12'(t);
    req.rect_right  = 12'(r);
    req.rect_bottom = 12'(b);
    req.target_set  = tgt;
    return req;
  endfunction

  function automatic dtt_pkg::in_item_t query_request(input int col, input int row);
    dtt_pkg::in_item_t req;
    req          = noise_request();
    req.req_type = dtt_pkg::REQ_QUERY;
    req.tile_col = 5'(col);
    req.tile_row = 4'(row);
    return req;
  endfunction

  function automatic dtt_pkg::in_item_t plain_request(input logic [2:0] code);
    dtt_pkg::in_item_t req;
    req          = noise_request();
    req.req_type = code;
    return req;
  endfunction

  // Mostly well-formed traffic: rectangles in and around the screen, queries mostly
  // in range, a few frame ends and clears, and some fully random requests.
  function automatic dtt_pkg::in_item_t random_request();
    int pick, l, t, w, h;
    pick = $urandom_range(99);
    l    = int'($urandom_range(700)) - 40;
    t    = int'($urandom_range(280)) - 20;
    w    = ($urandom_range(3) == 0) ? int'($urandom_range(640)) : int'($urandom_range(96));
    h    = ($urandom_range(3) == 0) ? int'($urandom_range(240)) : int'($urandom_range(48));
    if (pick < 7) return noise_request();
    if (pick < 45)
      return rect_request(l, t, l + w, t + h,
                          $urandom_range(1) ? dtt_pkg::TGT_NEWEST : 2'($urandom_range(3)));
    if (pick < 85)
      return query_request(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(19),
                           ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(14));
    if (pick < 95) return plain_request(dtt_pkg::REQ_END_FRAME);
    if (pick < 98) return plain_request(dtt_pkg::REQ_CLR_FG);
    return plain_request(dtt_pkg::REQ_CLR_SETS);
  endfunction

  task automatic pause_sender();
    int n = 0;
    while ($urandom_range(99) < gap_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Called at a rising edge; returns after the edge where the request is taken and any random pause after it.
  task automatic issue(input dtt_pkg::in_item_t req);
    in_item <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pause_sender();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_render(input logic en);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue(query_request(0, 0));
    issue(rect_request(-2048, -2048, 2047, 2047, dtt_pkg::TGT_NEWEST));
    // A tile dirty only in the newest set is not yet redrawn on the background.
    issue(query_request(19, 14));
    issue(plain_request(dtt_pkg::REQ_END_FRAME));
    issue(query_request(19, 14));
    issue(rect_request(32, 16, 63, 31, TGT_FG));
    issue(query_request(1, 1));
    issue(rect_request(64, 0, 95, 15, TGT_HALF));
    issue(query_request(2, 0));
    // Negative right and bottom still reach column and row zero.
    issue(rect_request(-100, -5, -1, -15, TGT_CARRY));
    issue(rect_request(100, 0, 50, 20, TGT_CARRY));
    issue(rect_request(2047, 2047, 2047, 2047, dtt_pkg::TGT_NEWEST));
    issue(rect_request(600, 200, 2047, 2047, TGT_FG));
    issue(query_request(20, 0));
    issue(query_request(31, 15));
    issue(query_request(0, 15));
    for (int k = 1; k <= 3; k++) begin
      issue(plain_request(3'(int'(dtt_pkg::REQ_CLR_SETS) + k)));
    end
    issue(plain_request(dtt_pkg::REQ_END_FRAME));
    issue(query_request(0, 0));
    issue(plain_request(dtt_pkg::REQ_CLR_FG));
    issue(query_request(1, 1));
    issue(plain_request(dtt_pkg::REQ_CLR_SETS));
    issue(query_request(19, 14));
    set_render(1'b0);
    issue(rect_request(0, 0, 639, 239, TGT_CARRY));
    issue(query_request(5, 5));
    issue(plain_request(dtt_pkg::REQ_END_FRAME));
    set_render(1'b1);
    issue(query_request(5, 5));

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 26 : (phase == 1) ? 65 : 0;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (i == 200) set_render(1'b0);
        if (i == 260) set_render(1'b1);
        issue(random_request());
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
